[rtl/ptfb_pkg.sv]
// Package for the page-tiled monochrome frame store.
// Holds the item, configuration and queue types, the operation codes and the
// back-end state codes. It depends on nothing else.
package ptfb_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned POS_X_W = 8;
  localparam int unsigned POS_Y_W = 7;
  localparam int unsigned PAGE_W  = POS_Y_W - 3;
  localparam int unsigned COL_W   = POS_X_W;
  // A linear store index is page * width + column, at most 15 * 256 + 255.
  localparam int unsigned LIN_W   = PAGE_W + COL_W;

  // Depth of the queue between the classifier and the executor.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_BLIT  = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_VISIBLE_WIDTH  = 2'd0,
    REG_VISIBLE_HEIGHT = 2'd1,
    REG_COLUMN_OFFSET  = 2'd2,
    REG_ROW_OFFSET     = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_READ,
    BK_MODIFY,
    BK_DONE
  } back_state_e;

  // Input item as it arrives on the port.
  typedef struct packed {
    logic [1:0]         func;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [3:0]         byte_group;
    logic [2:0]         page_sel;
    logic               pixel_on;
    logic [7:0]         pixel_byte;
  } in_item_t;

  // Result item as it leaves on the port.
  typedef struct packed {
    logic       accepted;
    logic [7:0] read_data;
    logic [2:0] disp_page;
    logic [7:0] disp_column;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] visible_width;
    logic [6:0] visible_height;
    logic [6:0] column_offset;
    logic [5:0] row_offset;
  } cfg_t;

  // Classified operation handed from the front end to the back end.
  typedef struct packed {
    func_e            func;
    logic             ok;
    logic [LIN_W-1:0] lin;
    logic [2:0]       bit_sel;
    logic             pixel_on;
    logic [7:0]       pixel_byte;
    logic [2:0]       disp_page;
    logic [7:0]       disp_column;
  } op_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/ptfb_front.sv]
// Front end of the frame store: takes input items, checks them against the
// visible window and turns them into store operations for the queue.
// Depends on ptfb_pkg.
module ptfb_front #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic                 in_valid_i,
  input  ptfb_pkg::in_item_t   in_item_i,
  output logic                 in_stall_o,
  input  ptfb_pkg::cfg_t       cfg_i,
  input  ptfb_pkg::q_status_t  q_stat_i,
  input  logic                 init_busy_i,
  output logic                 push_o,
  output ptfb_pkg::op_t        op_o
);

  localparam int unsigned WCMP_W = ptfb_pkg::COL_W + 1;
  localparam int unsigned HCMP_W = ptfb_pkg::POS_Y_W + 1;
  localparam int unsigned PROD_W = ptfb_pkg::LIN_W + 1;
  localparam logic [WCMP_W-1:0] MaxCols = WCMP_W'(MAX_COLUMNS);
  localparam logic [HCMP_W-1:0] MaxRows = HCMP_W'(MAX_ROWS);

  logic [WCMP_W-1:0]          width_lim;
  logic [HCMP_W-1:0]          height_lim;
  logic [WCMP_W-1:0]          x_ext;
  logic [HCMP_W-1:0]          y_ext;
  logic                       x_in;
  logic                       y_in;
  logic                       group_in;
  logic                       page_in;
  logic [ptfb_pkg::PAGE_W-1:0] page;
  logic [ptfb_pkg::COL_W-1:0]  col;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          lin_sum;
  ptfb_pkg::func_e            func;

  // The input waits while the queue is full or the store is being cleared
  // after reset.
  assign in_stall_o = q_stat_i.full | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // Effective window size, limited by the store dimensions.
  always_comb begin
    width_lim  = ({1'b0, cfg_i.visible_width} > MaxCols) ? MaxCols
                                                         : {1'b0, cfg_i.visible_width};
    height_lim = ({1'b0, cfg_i.visible_height} > MaxRows) ? MaxRows
                                                          : {1'b0, cfg_i.visible_height};
  end

  // Window checks.
  assign func     = ptfb_pkg::func_e'(in_item_i.func);
  assign x_ext    = {1'b0, in_item_i.pos_x};
  assign y_ext    = {1'b0, in_item_i.pos_y};
  assign x_in     = x_ext < width_lim;
  assign y_in     = y_ext < height_lim;
  assign group_in = (WCMP_W'({in_item_i.byte_group, 3'b000}) + WCMP_W'(8)) <= width_lim;
  assign page_in  = HCMP_W'({in_item_i.page_sel, 3'b000}) < height_lim;

  // Linear store index: page * width + column.
  always_comb begin
    page = (func == ptfb_pkg::FUNC_READ) ? ptfb_pkg::PAGE_W'(in_item_i.page_sel)
                                         : in_item_i.pos_y[ptfb_pkg::POS_Y_W-1:3];
    col  = (func == ptfb_pkg::FUNC_BLIT) ? ptfb_pkg::COL_W'({in_item_i.byte_group, 3'b000})
                                         : in_item_i.pos_x;
    prod    = PROD_W'(page) * PROD_W'(width_lim);
    lin_sum = prod + PROD_W'(col);
  end

  // Build the operation record.
  always_comb begin
    op_o            = '0;
    op_o.func       = func;
    op_o.lin        = lin_sum[ptfb_pkg::LIN_W-1:0];
    op_o.bit_sel    = in_item_i.pos_y[2:0];
    op_o.pixel_on   = in_item_i.pixel_on;
    op_o.pixel_byte = in_item_i.pixel_byte;
    unique case (func)
      ptfb_pkg::FUNC_DRAW:  op_o.ok = x_in & y_in;
      ptfb_pkg::FUNC_CLEAR: op_o.ok = 1'b1;
      ptfb_pkg::FUNC_BLIT:  op_o.ok = y_in & group_in;
      ptfb_pkg::FUNC_READ: begin
        op_o.ok = x_in & page_in;
        if (x_in && page_in) begin
          op_o.disp_page   = in_item_i.page_sel + cfg_i.row_offset[5:3];
          op_o.disp_column = {1'b0, in_item_i.pos_x[6:0]} + {1'b0, cfg_i.column_offset};
        end
      end
    endcase
  end

endmodule

[rtl/ptfb_queue.sv]
// Short queue of classified operations between front and back end.
// Depends on ptfb_pkg for the entry type and the depth.
module ptfb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptfb_pkg::op_t       push_op_i,
  input  logic                pop_i,
  output ptfb_pkg::op_t       head_o,
  output ptfb_pkg::q_status_t stat_o
);

  ptfb_pkg::op_t                 entries [ptfb_pkg::QDEPTH];
  logic [ptfb_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ptfb_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ptfb_pkg::QCNT_W-1:0]   count_q, count_d;

  assign stat_o.full  = count_q == ptfb_pkg::QCNT_W'(ptfb_pkg::QDEPTH);
  assign stat_o.empty = count_q == '0;
  assign head_o       = entries[rd_ptr_q];

  // Pointer and fill count update; the depth is a power of two so the
  // pointers wrap on their own.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[rtl/ptfb_back.sv]
// Back end of the frame store: owns the store memory and carries out draw,
// blit, read and clear operations, including the clearing pass after reset.
// Depends on ptfb_pkg.
module ptfb_back #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptfb_pkg::q_status_t q_stat_i,
  input  ptfb_pkg::op_t       q_head_i,
  output logic                q_pop_o,
  output logic                init_busy_o,
  output logic                out_valid_o,
  output ptfb_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);

  localparam int unsigned STORE_BYTES = MAX_COLUMNS * (MAX_ROWS / 8);
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned FULL_W      = ptfb_pkg::LIN_W + 1;
  localparam logic [FULL_W-1:0] StoreEnd  = FULL_W'(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LastAddr  = ADDR_W'(STORE_BYTES - 1);

  logic [7:0]              store [STORE_BYTES];
  logic [7:0]              rdata_q;

  ptfb_pkg::back_state_e   st_q, st_d;
  ptfb_pkg::op_t           cur_q, cur_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [ADDR_W-1:0]       swp_q, swp_d;
  logic                    sweep_op_q, sweep_op_d;
  ptfb_pkg::out_item_t     pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  ptfb_pkg::out_item_t     out_item_q;

  logic [FULL_W-1:0]       wr_full;
  logic [FULL_W-1:0]       rd_full;
  logic                    wr_in_store;
  logic                    rd_in_store;
  logic                    more;
  logic                    res_free;
  logic                    new_bit;
  logic [7:0]              bit_mask;
  logic [7:0]              mod_byte;
  logic                    mem_we;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [7:0]              mem_wdata;

  assign init_busy_o = (st_q == ptfb_pkg::BK_SWEEP) && !sweep_op_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign res_free    = !out_valid_q || !out_stall_i;

  // Byte addresses: the write side works on byte cnt, the read side fetches
  // the next byte while in the modify state.
  assign wr_full     = {1'b0, cur_q.lin} + FULL_W'(cnt_q);
  assign rd_full     = wr_full + FULL_W'(st_q == ptfb_pkg::BK_MODIFY);
  assign wr_in_store = wr_full < StoreEnd;
  assign rd_in_store = rd_full < StoreEnd;
  assign more        = (cur_q.func == ptfb_pkg::FUNC_BLIT) && (cnt_q != 3'd7);

  // New value of the addressed bit and the modified byte.
  always_comb begin
    new_bit  = (cur_q.func == ptfb_pkg::FUNC_DRAW) ? cur_q.pixel_on
                                                   : cur_q.pixel_byte[3'd7 - cnt_q];
    bit_mask = 8'b1 << cur_q.bit_sel;
    mod_byte = (rdata_q & ~bit_mask) | (new_bit ? bit_mask : 8'h00);
  end

  // Sequencer: next state, memory controls and result capture.
  always_comb begin
    st_d       = st_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    swp_d      = swp_q;
    sweep_op_d = sweep_op_q;
    pend_d     = pend_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wr_full[ADDR_W-1:0];
    mem_wdata  = mod_byte;
    unique case (st_q)
      ptfb_pkg::BK_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = swp_q;
        mem_wdata = 8'h00;
        swp_d     = swp_q + 1'b1;
        if (swp_q == LastAddr) begin
          swp_d = '0;
          if (sweep_op_q) begin
            pend_d          = '0;
            pend_d.accepted = 1'b1;
            st_d            = ptfb_pkg::BK_DONE;
          end else begin
            st_d = ptfb_pkg::BK_IDLE;
          end
        end
      end
      ptfb_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          cnt_d   = '0;
          if (!q_head_i.ok) begin
            pend_d = '0;
            st_d   = ptfb_pkg::BK_DONE;
          end else if (q_head_i.func == ptfb_pkg::FUNC_CLEAR) begin
            sweep_op_d = 1'b1;
            swp_d      = '0;
            st_d       = ptfb_pkg::BK_SWEEP;
          end else begin
            st_d = ptfb_pkg::BK_READ;
          end
        end
      end
      ptfb_pkg::BK_READ: begin
        mem_re = rd_in_store;
        st_d   = ptfb_pkg::BK_MODIFY;
      end
      ptfb_pkg::BK_MODIFY: begin
        mem_re = rd_in_store && more;
        mem_we = wr_in_store && (cur_q.func != ptfb_pkg::FUNC_READ);
        if (more) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          pend_d.accepted    = 1'b1;
          pend_d.read_data   = ((cur_q.func == ptfb_pkg::FUNC_READ) && wr_in_store)
                               ? rdata_q : 8'h00;
          pend_d.disp_page   = cur_q.disp_page;
          pend_d.disp_column = cur_q.disp_column;
          st_d               = ptfb_pkg::BK_DONE;
        end
      end
      ptfb_pkg::BK_DONE: begin
        if (res_free) begin
          st_d = ptfb_pkg::BK_IDLE;
        end
      end
      default: st_d = ptfb_pkg::BK_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if ((st_q == ptfb_pkg::BK_DONE) && res_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ptfb_pkg::BK_SWEEP;
      cnt_q       <= '0;
      swp_q       <= '0;
      sweep_op_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      swp_q       <= swp_d;
      sweep_op_q  <= sweep_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    if ((st_q == ptfb_pkg::BK_DONE) && res_free) begin
      out_item_q <= pend_q;
    end
  end

  // Frame store memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store[rd_full[ADDR_W-1:0]];
    end
  end

  // An operation is only taken from a queue that holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> !q_stat_i.empty)
    else $error("pop from an empty operation queue");

  // No result can appear before the clearing pass after reset is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni) init_busy_o |-> !out_valid_o)
    else $error("result delivered during the reset clearing pass");

  // A draw touches exactly one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ptfb_pkg::BK_MODIFY && cur_q.func == ptfb_pkg::FUNC_DRAW)
    |=> (st_q == ptfb_pkg::BK_DONE))
    else $error("draw did not finish after one byte");

  // A finished result waiting for the output register is held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ptfb_pkg::BK_DONE && !res_free)
    |=> (st_q == ptfb_pkg::BK_DONE && $stable(pend_q)))
    else $error("pending result lost while the output was stalled");

  // The store is written only by the clearing pass or a modify step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (st_q == ptfb_pkg::BK_SWEEP || st_q == ptfb_pkg::BK_MODIFY))
    else $error("store written outside a sweep or modify step");

endmodule

[rtl/page_tiled_mono_framebuffer_core.sv]
// Top level of the page-tiled monochrome frame store.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on ptfb_pkg, ptfb_front, ptfb_queue and ptfb_back.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------
//  input    | in_valid_i/in_stall_o | in_item_i  (func, pos, group, ...)
//  result   | out_valid_o/out_stall_i | out_item_o (accepted, read data, ...)
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// The back end takes one item at a time, stepped by the single store port
// sequencer: draw and read do a read and a modify step, blit one overlapped
// read-modify-write per byte, clear a clearing pass; rejected items skip the store.
// After reset a clearing pass writes every store byte, one per cycle, while
// input items wait on stall. A two-entry queue lets the front end take items
// while the back end works, and the result register lets the next item
// proceed while a result waits.
module page_tiled_mono_framebuffer_core #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ptfb_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output ptfb_pkg::out_item_t out_item_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  ptfb_pkg::cfg_t      cfg_q;
  ptfb_pkg::q_status_t q_stat;
  ptfb_pkg::op_t       push_op;
  ptfb_pkg::op_t       head_op;
  logic                push;
  logic                pop;
  logic                init_busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.visible_width  <= 8'd128;
      cfg_q.visible_height <= 7'd64;
      cfg_q.column_offset  <= 7'd0;
      cfg_q.row_offset     <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (ptfb_pkg::cfg_reg_e'(cfg_idx_i))
        ptfb_pkg::REG_VISIBLE_WIDTH:  cfg_q.visible_width  <= cfg_data_i;
        ptfb_pkg::REG_VISIBLE_HEIGHT: cfg_q.visible_height <= cfg_data_i[6:0];
        ptfb_pkg::REG_COLUMN_OFFSET:  cfg_q.column_offset  <= cfg_data_i[6:0];
        ptfb_pkg::REG_ROW_OFFSET:     cfg_q.row_offset     <= cfg_data_i[5:0];
      endcase
    end
  end

  ptfb_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .init_busy_i (init_busy),
    .push_o      (push),
    .op_o        (push_op)
  );

  ptfb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head_op),
    .stat_o    (q_stat)
  );

  ptfb_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_head_i    (head_op),
    .q_pop_o     (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

[dv/ptfb_frame_check_pkg.sv]
// Frame store predictor and result checker for the page-tiled monochrome core.
// Holds a copy of the store and the window registers and keeps the results still due.
// Depends on ptfb_pkg.
package ptfb_frame_check_pkg;
  import ptfb_pkg::*;

  localparam int unsigned FB_COLUMNS = 128;
  localparam int unsigned FB_ROWS    = 64;
  localparam int unsigned FB_BYTES   = FB_COLUMNS * (FB_ROWS / 8);
  localparam int unsigned REPORT_MAX = 10;

  class frame_store_checker;
    logic [7:0]  store [FB_BYTES];
    cfg_t        window;
    out_item_t   results_due [$];
    int unsigned failures;
    int unsigned reported;

    function new();
      foreach (store[i]) begin
        store[i] = 8'h00;
      end
      window.visible_width  = 8'd128;
      window.visible_height = 7'd64;
      window.column_offset  = 7'd0;
      window.row_offset     = 6'd0;
      failures = 0;
      reported = 0;
    endfunction

    // Register writes keep only the bits that each register holds.
    function void write_reg(cfg_reg_e idx, logic [7:0] data);
      case (idx)
        REG_VISIBLE_WIDTH:  window.visible_width  = data;
        REG_VISIBLE_HEIGHT: window.visible_height = data[6:0];
        REG_COLUMN_OFFSET:  window.column_offset  = data[6:0];
        REG_ROW_OFFSET:     window.row_offset     = data[5:0];
        default: ;
      endcase
    endfunction

    // The window is clipped to the size of the store.
    function int unsigned width_eff();
      return (window.visible_width > FB_COLUMNS) ? FB_COLUMNS : window.visible_width;
    endfunction

    function int unsigned height_eff();
      return (window.visible_height > FB_ROWS) ? FB_ROWS : window.visible_height;
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction

    function void put_pixel(int unsigned idx, int unsigned bit_no, logic on);
      if (idx < FB_BYTES) begin
        store[idx][bit_no] = on;
      end
    endfunction

    // Apply one accepted item to the store copy and queue the result it gives.
    function void note_item(in_item_t it);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      out_item_t   res;
      w   = width_eff();
      h   = height_eff();
      res = '0;
      case (it.func)
        FUNC_DRAW: begin
          if (it.pos_x < w && it.pos_y < h) begin
            put_pixel((it.pos_y >> 3) * w + it.pos_x, it.pos_y[2:0], it.pixel_on);
            res.accepted = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          foreach (store[i]) begin
            store[i] = 8'h00;
          end
          res.accepted = 1'b1;
        end
        FUNC_BLIT: begin
          if (it.pos_y < h && it.byte_group * 8 + 8 <= w) begin
            // Bit 7 of the byte is the leftmost pixel of the group.
            for (int i = 0; i < 8; i++) begin
              put_pixel((it.pos_y >> 3) * w + it.byte_group * 8 + i, it.pos_y[2:0],
                        it.pixel_byte[7-i]);
            end
            res.accepted = 1'b1;
          end
        end
        default: begin
          if (it.pos_x < w && it.page_sel * 8 < h) begin
            idx             = it.page_sel * w + it.pos_x;
            res.read_data   = (idx < FB_BYTES) ? store[idx] : 8'h00;
            res.disp_page   = it.page_sel + window.row_offset[5:3];
            res.disp_column = {1'b0, it.pos_x[6:0]} + {1'b0, window.column_offset};
            res.accepted    = 1'b1;
          end
        end
      endcase
      results_due.push_back(res);
    endfunction

    // Compare one result from the block with the oldest one due.
    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("unexpected result: acc=%0d data=%02h page=%0d col=%02h",
                   got.accepted, got.read_data, got.disp_page, got.disp_column);
        end
        return;
      end
      want = results_due.pop_front();
      if (got.accepted  !== want.accepted  || got.read_data   !== want.read_data ||
          got.disp_page !== want.disp_page || got.disp_column !== want.disp_column) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("mismatch: expected acc=%0d data=%02h page=%0d col=%02h,",
                   want.accepted, want.read_data, want.disp_page, want.disp_column);
          $display("          got acc=%0d data=%02h page=%0d col=%02h",
                   got.accepted, got.read_data, got.disp_page, got.disp_column);
        end
      end
    endfunction
  endclass

endpackage

[dv/testbench.sv]
// Testbench for page_tiled_mono_framebuffer_core: directed and random items under
// several window settings, with random sender gaps and receiver stalls.
// Depends on ptfb_pkg, ptfb_frame_check_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptfb_pkg::*;
  import ptfb_frame_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_item = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_item;
  logic       out_stall = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;

  int unsigned cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_count = 0;

  frame_store_checker frame_chk;

  page_tiled_mono_framebuffer_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_item_i  (in_item),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_item_o (out_item),
    .out_stall_i(out_stall),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle counter ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Watch both channels; an item moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        frame_chk.note_item(in_item);
      end
      if (out_valid && !out_stall) begin
        frame_chk.check_result(out_item);
      end
    end
  end

  // The receiver switches between stall patterns every so often.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left = stall_left - 1;
    end
    stall_count = stall_count + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ((stall_count % 24) >= 14);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // Wait until every result due has come back.
  task automatic wait_results();
    while (frame_chk.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write all four window registers while the block is idle.
  task automatic set_window(logic [7:0] w, logic [7:0] h, logic [7:0] col, logic [7:0] row);
    cfg_reg_e   idx [4];
    logic [7:0] val [4];
    idx = '{REG_VISIBLE_WIDTH, REG_VISIBLE_HEIGHT, REG_COLUMN_OFFSET, REG_ROW_OFFSET};
    val = '{w, h, col, row};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      frame_chk.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_op(logic [1:0] func, int unsigned x, int unsigned y,
                                       int unsigned grp, int unsigned page, logic on,
                                       logic [7:0] pix);
    in_item_t it;
    it            = '0;
    it.func       = func;
    it.pos_x      = x[7:0];
    it.pos_y      = y[6:0];
    it.byte_group = grp[3:0];
    it.page_sel   = page[2:0];
    it.pixel_on   = on;
    it.pixel_byte = pix;
    return it;
  endfunction

  // Mostly well-formed items inside the window; the rest is raw noise.
  function automatic in_item_t random_item(int unsigned w, int unsigned h);
    logic [63:0] raw;
    in_item_t    it;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      it.func = FUNC_CLEAR;
    end else if (pick < 36) begin
      it.func = FUNC_DRAW;
      if (w > 0 && h > 0) begin
        it.pos_x = 8'($urandom_range(0, w - 1));
        it.pos_y = 7'($urandom_range(0, h - 1));
      end
    end else if (pick < 60) begin
      it.func = FUNC_BLIT;
      if (w >= 8 && h > 0) begin
        it.pos_y      = 7'($urandom_range(0, h - 1));
        it.byte_group = 4'($urandom_range(0, w / 8 - 1));
      end
    end else if (pick < 90) begin
      it.func = FUNC_READ;
      if (w > 0 && h > 0) begin
        it.pos_x    = 8'($urandom_range(0, w - 1));
        it.page_sel = 3'($urandom_range(0, (h - 1) / 8));
      end
    end
    return it;
  endfunction

  // Random items in bursts with random gaps; now and then wait for all results.
  task automatic run_items(int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 40);
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 40);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        if ($urandom_range(0, 99) < 3) begin
          in_valid <= 1'b0;
          @(negedge clk);
          wait_results();
        end
      end
      send_item(random_item(frame_chk.width_eff(), frame_chk.height_eff()));
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Main sequence: reset, directed items, then one random phase per window setting.
  initial begin
    in_item_t   directed [$];
    logic [7:0] rw;
    logic [7:0] rh;
    frame_chk = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window is 128 x 64 with no offsets.
    directed.push_back(make_op(FUNC_READ,  0,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  0,   0,   0,  0, 1'b1, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  127, 63,  0,  0, 1'b1, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  128, 5,   0,  0, 1'b1, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  5,   64,  0,  0, 1'b1, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  255, 127, 15, 7, 1'b1, 8'hFF));
    directed.push_back(make_op(FUNC_READ,  0,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  127, 0,   0,  7, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  128, 0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  255, 127, 15, 7, 1'b1, 8'hFF));
    directed.push_back(make_op(FUNC_BLIT,  0,   0,   0,  0, 1'b0, 8'hFF));
    directed.push_back(make_op(FUNC_BLIT,  0,   63,  15, 0, 1'b0, 8'hA5));
    directed.push_back(make_op(FUNC_BLIT,  0,   64,  0,  0, 1'b0, 8'hFF));
    directed.push_back(make_op(FUNC_READ,  7,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  120, 0,   0,  7, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  0,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  0,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_BLIT,  0,   63,  15, 0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_READ,  121, 0,   0,  7, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_CLEAR, 255, 127, 15, 7, 1'b1, 8'hFF));
    directed.push_back(make_op(FUNC_READ,  3,   0,   0,  0, 1'b0, 8'h00));
    directed.push_back(make_op(FUNC_DRAW,  64,  31,  0,  0, 1'b1, 8'h00));
    directed.push_back(make_op(FUNC_READ,  64,  0,   0,  3, 1'b0, 8'h00));
    foreach (directed[i]) begin
      send_item(directed[i]);
    end
    in_valid <= 1'b0;
    run_items(150);

    // Window settings, extremes and register masking among them.
    for (int p = 0; p < 10; p++) begin
      @(negedge clk);
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (p)
        0: set_window(8'd128, 8'd64, 8'd0, 8'd0);
        1: set_window(8'd8, 8'd8, 8'd127, 8'd63);
        2: set_window(8'd200, 8'd127, 8'd64, 8'd8);
        3: set_window(8'd255, 8'd255, 8'd128, 8'd255);
        4: set_window(8'd64, 8'd32, 8'($urandom), 8'($urandom));
        5: set_window(8'd0, 8'd0, 8'd5, 8'd17);
        6: set_window(8'd100, 8'd20, 8'd33, 8'd47);
        default: begin
          rw = 8'($urandom_range(1, 16) * 8);
          rh = 8'($urandom_range(1, 8) * 8);
          set_window(rw, rh, 8'($urandom), 8'($urandom));
        end
      endcase
      run_items((p == 5) ? 40 : 160);
    end

    // Let everything drain, then give the verdict.
    @(negedge clk);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (frame_chk.failures == 0 && frame_chk.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
